// ===== hdl/cll_pkg.sv =====
package cll_pkg;

  // Field widths of the byte channel, the result channel and the register port.
  localparam int CHAR_W     = 8;
  localparam int TOK_NUM_W  = 4;
  localparam int SEG_NUM_W  = 4;
  localparam int COUNT_W    = 5;
  localparam int LIMIT_W    = 5;
  localparam int CFG_IDX_W  = 1;

  // Largest token or segment limit that the counters honour.
  localparam logic [LIMIT_W-1:0] LIMIT_MAX = LIMIT_W'(16);

  // Characters with a meaning of their own.
  localparam logic [CHAR_W-1:0] CH_HASH  = 8'h23;
  localparam logic [CHAR_W-1:0] CH_SEMI  = 8'h3B;
  localparam logic [CHAR_W-1:0] CH_QUOTE = 8'h22;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

  // Register indexes of the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TOKEN_LIMIT   = 1'b0,
    REG_SEGMENT_LIMIT = 1'b1
  } cfg_index_e;

  // Lexer state carried from one byte to the next.
  typedef struct packed {
    logic                 quote_open;
    logic                 in_comment;
    logic                 prev_blank;
    logic                 in_token;
    logic [COUNT_W-1:0]   token_count;
    logic [SEG_NUM_W-1:0] segment_count;
    logic                 token_overflow;
    logic                 segment_overflow;
  } cll_state_t;

  localparam cll_state_t STATE_RESET = '{
    quote_open:       1'b0,
    in_comment:       1'b0,
    prev_blank:       1'b1,
    in_token:         1'b0,
    token_count:      '0,
    segment_count:    '0,
    token_overflow:   1'b0,
    segment_overflow: 1'b0
  };

  // One result item.
  typedef struct packed {
    logic [CHAR_W-1:0]    out_char;
    logic                 char_valid;
    logic                 token_start;
    logic [TOK_NUM_W-1:0] token_number;
    logic [SEG_NUM_W-1:0] segment_number;
    logic                 segment_end;
    logic [COUNT_W-1:0]   segment_tokens;
    logic                 segment_overflow;
    logic                 line_end;
    logic                 line_overflow;
    logic                 char_dropped;
  } cll_result_t;

  // A limit of zero acts as one, and anything above the maximum as the maximum.
  function automatic logic [LIMIT_W-1:0] eff_limit(logic [LIMIT_W-1:0] r);
    logic [LIMIT_W-1:0] v;
    if (r == '0) begin
      v = LIMIT_W'(1);
    end else if (r > LIMIT_MAX) begin
      v = LIMIT_MAX;
    end else begin
      v = r;
    end
    return v;
  endfunction

  // Index of the latest token, zero when there is none yet.
  function automatic logic [TOK_NUM_W-1:0] token_index(logic [COUNT_W-1:0] cnt);
    logic [COUNT_W-1:0] m;
    m = cnt - COUNT_W'(1);
    return (cnt == '0) ? '0 : m[TOK_NUM_W-1:0];
  endfunction

endpackage

// ===== hdl/cll_if.sv =====
// Byte channel into the lexer.
interface cll_in_if;
  logic                        valid;
  logic                        ready;
  logic [cll_pkg::CHAR_W-1:0]  char_code;
  logic                        is_end;

  modport source (output valid, output char_code, output is_end, input ready);
  modport sink   (input valid, input char_code, input is_end, output ready);
endinterface

// Result channel out of the lexer.
interface cll_out_if;
  logic                           valid;
  logic                           ready;
  logic [cll_pkg::CHAR_W-1:0]     out_char;
  logic                           char_valid;
  logic                           token_start;
  logic [cll_pkg::TOK_NUM_W-1:0]  token_number;
  logic [cll_pkg::SEG_NUM_W-1:0]  segment_number;
  logic                           segment_end;
  logic [cll_pkg::COUNT_W-1:0]    segment_tokens;
  logic                           segment_overflow;
  logic                           line_end;
  logic                           line_overflow;
  logic                           char_dropped;

  modport source (
    output valid, output out_char, output char_valid, output token_start,
    output token_number, output segment_number, output segment_end,
    output segment_tokens, output segment_overflow, output line_end,
    output line_overflow, output char_dropped, input ready
  );
  modport sink (
    input valid, input out_char, input char_valid, input token_start,
    input token_number, input segment_number, input segment_end,
    input segment_tokens, input segment_overflow, input line_end,
    input line_overflow, input char_dropped, output ready
  );
endinterface

// ===== hdl/cll_lex_step.sv =====
module cll_lex_step (
  input  cll_pkg::cll_state_t            st_i,
  input  logic [cll_pkg::CHAR_W-1:0]     char_i,
  input  logic                           is_end_i,
  input  logic                           line_full_i,
  input  logic [cll_pkg::LIMIT_W-1:0]    token_limit_i,
  input  logic [cll_pkg::LIMIT_W-1:0]    segment_limit_i,
  output cll_pkg::cll_state_t            st_o,
  output cll_pkg::cll_result_t           res_o,
  output logic                           take_o
);
  import cll_pkg::*;

  // One byte of lexing: next state and the result item.
  always_comb begin
    logic               blank;
    logic               start;
    logic               closing;
    logic [LIMIT_W-1:0] tok_lim;
    logic [LIMIT_W-1:0] seg_lim;
    cll_state_t         nx;
    cll_result_t        res;

    blank   = char_i inside {CH_SPACE, CH_TAB};
    start   = 1'b0;
    closing = 1'b0;
    tok_lim = eff_limit(token_limit_i);
    seg_lim = eff_limit(segment_limit_i);
    nx      = st_i;
    res     = '0;
    take_o  = 1'b0;

    if (is_end_i) begin
      // End of line reports the last segment and starts a fresh line.
      res.token_number     = token_index(st_i.token_count);
      res.segment_number   = st_i.segment_count;
      res.segment_end      = 1'b1;
      res.segment_tokens   = st_i.token_count;
      res.segment_overflow = st_i.token_overflow;
      res.line_end         = 1'b1;
      res.line_overflow    = st_i.segment_overflow;
      nx                   = STATE_RESET;
    end else if (st_i.in_comment || line_full_i) begin
      // Comment text and bytes past the line length leave the state alone.
      res.token_number   = token_index(st_i.token_count);
      res.segment_number = st_i.segment_count;
      res.line_overflow  = st_i.segment_overflow;
      res.char_dropped   = 1'b1;
    end else begin
      take_o = 1'b1;
      if (!st_i.quote_open && (char_i == CH_HASH) && st_i.prev_blank) begin
        nx.in_comment    = 1'b1;
        res.char_dropped = 1'b1;
      end else if (char_i == CH_QUOTE) begin
        nx.quote_open = !st_i.quote_open;
        start         = !st_i.in_token;
      end else if ((char_i == CH_SEMI) && !st_i.quote_open) begin
        closing              = 1'b1;
        res.token_number     = token_index(st_i.token_count);
        res.segment_number   = st_i.segment_count;
        res.segment_end      = 1'b1;
        res.segment_tokens   = st_i.token_count;
        res.segment_overflow = st_i.token_overflow;
        if (({1'b0, st_i.segment_count} + LIMIT_W'(1)) >= seg_lim) begin
          nx.segment_overflow = 1'b1;
        end else begin
          nx.segment_count = st_i.segment_count + SEG_NUM_W'(1);
        end
        nx.token_count    = '0;
        nx.token_overflow = 1'b0;
        nx.in_token       = 1'b0;
      end else if (blank && !st_i.quote_open) begin
        nx.in_token = 1'b0;
      end else begin
        start          = !st_i.in_token;
        res.out_char   = char_i;
        res.char_valid = 1'b1;
      end

      // A new token counts against the limit, saturating once it is reached.
      if (start) begin
        res.token_start = 1'b1;
        nx.in_token     = 1'b1;
        if (st_i.token_count >= tok_lim) begin
          nx.token_overflow = 1'b1;
        end else begin
          nx.token_count = st_i.token_count + COUNT_W'(1);
        end
      end
      nx.prev_blank = blank;

      if (!closing) begin
        res.token_number   = token_index(nx.token_count);
        res.segment_number = nx.segment_count;
      end
      res.line_overflow = nx.segment_overflow;
    end

    st_o  = nx;
    res_o = res;
  end

endmodule

// ===== hdl/command_line_lexer.sv =====
// Channel   Direction  Transaction
// in_i      sink       one line byte (char_code) or the end-of-line item (is_end)
// out_o     source     one result item per input item
// cfg       write      token_limit (index 0), segment_limit (index 1)
//
// Each item passes through the input register and then the result
// register; one item is accepted every cycle while out_o does not stall.
// The lexer state is updated in the single step between those registers.
// Reset clears the lexer state, sets both limits to 16 and empties both
// registers. A stall on out_o holds the result and lets one more item wait.
module command_line_lexer #(
  parameter int LINE_LENGTH = 512
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [cll_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [cll_pkg::LIMIT_W-1:0]       cfg_data_i,
  cll_in_if.sink                            in_i,
  cll_out_if.source                         out_o
);
  import cll_pkg::*;

  localparam int BC_W = $clog2(LINE_LENGTH);
  localparam logic [BC_W-1:0] BYTE_MAX = BC_W'(LINE_LENGTH - 1);

  logic [LIMIT_W-1:0] tok_lim_q;
  logic [LIMIT_W-1:0] seg_lim_q;
  logic               in_valid_q;
  logic [CHAR_W-1:0]  in_char_q;
  logic               in_end_q;
  cll_state_t         st_q, st_d;
  logic [BC_W-1:0]    byte_cnt_q, byte_cnt_d;
  logic               out_valid_q;
  cll_result_t        res_q, res_d;
  logic               advance;
  logic               take;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_lim_q <= LIMIT_MAX;
      seg_lim_q <= LIMIT_MAX;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_TOKEN_LIMIT:   tok_lim_q <= cfg_data_i;
        REG_SEGMENT_LIMIT: seg_lim_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // An item moves on when the result register is free or being emptied.
  assign advance    = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || advance;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      in_char_q <= in_i.char_code;
      in_end_q  <= in_i.is_end;
    end
  end

  // Lexing step.
  cll_lex_step u_step (
    .st_i            (st_q),
    .char_i          (in_char_q),
    .is_end_i        (in_end_q),
    .line_full_i     (byte_cnt_q >= BYTE_MAX),
    .token_limit_i   (tok_lim_q),
    .segment_limit_i (seg_lim_q),
    .st_o            (st_d),
    .res_o           (res_d),
    .take_o          (take)
  );

  // Byte counter of the current line.
  always_comb begin
    byte_cnt_d = byte_cnt_q;
    if (in_end_q) begin
      byte_cnt_d = '0;
    end else if (take) begin
      byte_cnt_d = byte_cnt_q + BC_W'(1);
    end
  end

  // Lexer state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q       <= STATE_RESET;
      byte_cnt_q <= '0;
    end else if (advance) begin
      st_q       <= st_d;
      byte_cnt_q <= byte_cnt_d;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid            = out_valid_q;
  assign out_o.out_char         = res_q.out_char;
  assign out_o.char_valid       = res_q.char_valid;
  assign out_o.token_start      = res_q.token_start;
  assign out_o.token_number     = res_q.token_number;
  assign out_o.segment_number   = res_q.segment_number;
  assign out_o.segment_end      = res_q.segment_end;
  assign out_o.segment_tokens   = res_q.segment_tokens;
  assign out_o.segment_overflow = res_q.segment_overflow;
  assign out_o.line_end         = res_q.line_end;
  assign out_o.line_overflow    = res_q.line_overflow;
  assign out_o.char_dropped     = res_q.char_dropped;

endmodule

// ===== hdl/cll_checker.sv =====
module cll_checker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             out_valid_i,
  input  logic                             out_ready_i,
  input  cll_pkg::cll_result_t             out_res_i
);
  import cll_pkg::*;

  // A stalled result transaction keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_res_i))
    else $error("result changed while stalled");

  // The end-of-line result always closes a segment.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_res_i.line_end |-> out_res_i.segment_end)
    else $error("line end without segment end");

  // A dropped byte carries no token or segment marks.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_res_i.char_dropped |->
      !out_res_i.char_valid && !out_res_i.token_start &&
      !out_res_i.segment_end && !out_res_i.line_end)
    else $error("dropped byte with token or segment marks");

  // An overflowing segment has counted tokens, and content is never a closing byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_res_i.segment_overflow |->
      (out_res_i.segment_tokens != '0) && out_res_i.segment_end)
    else $error("segment overflow without tokens");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_res_i.char_valid |-> !out_res_i.segment_end)
    else $error("token content on a closing result");

endmodule

bind command_line_lexer cll_checker u_cll_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_res_i   ({out_o.out_char, out_o.char_valid, out_o.token_start,
                 out_o.token_number, out_o.segment_number, out_o.segment_end,
                 out_o.segment_tokens, out_o.segment_overflow, out_o.line_end,
                 out_o.line_overflow, out_o.char_dropped})
);

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import cll_pkg::*;

  localparam int LINE_LEN   = 512;
  localparam int TIMEOUT_NS = 2_000_000;

  // One byte of a command line, or the end-of-line marker.
  typedef struct packed {
    logic [CHAR_W-1:0] code;
    logic              eol;
  } line_item_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  cfg_index_e cfg_index;
  logic [LIMIT_W-1:0] cfg_data;

  cll_in_if  in_ch ();
  cll_out_if out_ch ();

  command_line_lexer #(
    .LINE_LENGTH(LINE_LEN)
  ) uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data),
    .in_i       (in_ch),
    .out_o      (out_ch)
  );

  line_item_t  pending_items[$];
  cll_result_t expected_marks[$];
  int          items_queued;
  int          error_count;
  int          tx_idle_pct;
  int          rx_idle_pct;
  logic        byte_taken;

  // Shadow of the limit registers and of the lexer's own state.
  logic [LIMIT_W-1:0] tok_limit_q;
  logic [LIMIT_W-1:0] seg_limit_q;
  logic               quote_q;
  logic               comment_q;
  logic               blank_q;
  logic               token_q;
  logic [COUNT_W-1:0] tok_cnt_q;
  logic [COUNT_W-1:0] seg_cnt_q;
  logic               tok_ovf_q;
  logic               seg_ovf_q;
  logic [9:0]         taken_q;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // A limit of zero behaves as one; anything above the maximum is clipped.
  function automatic logic [LIMIT_W-1:0] usable_limit(input logic [LIMIT_W-1:0] r);
    if (r == '0) return LIMIT_W'(1);
    if (r > LIMIT_MAX) return LIMIT_MAX;
    return r;
  endfunction

  function automatic logic [TOK_NUM_W-1:0] latest_token(input logic [COUNT_W-1:0] cnt);
    return (cnt == '0) ? '0 : TOK_NUM_W'(cnt - COUNT_W'(1));
  endfunction

  function automatic void clear_line();
    quote_q   = 1'b0;
    comment_q = 1'b0;
    blank_q   = 1'b1;
    token_q   = 1'b0;
    tok_cnt_q = '0;
    seg_cnt_q = '0;
    tok_ovf_q = 1'b0;
    seg_ovf_q = 1'b0;
    taken_q   = '0;
  endfunction

  // A new token either counts or, at the limit, marks the segment as overflowed.
  function automatic void count_token();
    token_q = 1'b1;
    if (tok_cnt_q >= usable_limit(tok_limit_q)) begin
      tok_ovf_q = 1'b1;
    end else begin
      tok_cnt_q = tok_cnt_q + COUNT_W'(1);
    end
  endfunction

  // Works out the token marks for one byte and advances the shadow state.
  task automatic tokenise_byte(input logic [CHAR_W-1:0] ch, input logic eol,
                               output cll_result_t r);
    logic blank;
    logic closing;
    blank   = (ch == CH_SPACE) || (ch == CH_TAB);
    closing = 1'b0;
    r       = '0;
    if (eol) begin
      r.token_number     = latest_token(tok_cnt_q);
      r.segment_number   = seg_cnt_q[SEG_NUM_W-1:0];
      r.segment_end      = 1'b1;
      r.segment_tokens   = tok_cnt_q;
      r.segment_overflow = tok_ovf_q;
      r.line_end         = 1'b1;
      r.line_overflow    = seg_ovf_q;
      clear_line();
    end else if (comment_q || taken_q >= LINE_LEN - 1) begin
      // Inside a comment or past the line length nothing changes.
      r.token_number   = latest_token(tok_cnt_q);
      r.segment_number = seg_cnt_q[SEG_NUM_W-1:0];
      r.line_overflow  = seg_ovf_q;
      r.char_dropped   = 1'b1;
    end else begin
      taken_q = taken_q + 10'd1;
      if (!quote_q && ch == CH_HASH && blank_q) begin
        comment_q      = 1'b1;
        r.char_dropped = 1'b1;
      end else if (ch == CH_QUOTE) begin
        quote_q = !quote_q;
        if (!token_q) begin
          r.token_start = 1'b1;
          count_token();
        end
      end else if (ch == CH_SEMI && !quote_q) begin
        // The closing result reports the segment before the counters move on.
        closing            = 1'b1;
        r.token_number     = latest_token(tok_cnt_q);
        r.segment_number   = seg_cnt_q[SEG_NUM_W-1:0];
        r.segment_end      = 1'b1;
        r.segment_tokens   = tok_cnt_q;
        r.segment_overflow = tok_ovf_q;
        if (int'(seg_cnt_q) + 1 >= int'(usable_limit(seg_limit_q))) begin
          seg_ovf_q = 1'b1;
        end else begin
          seg_cnt_q = seg_cnt_q + COUNT_W'(1);
        end
        tok_cnt_q = '0;
        tok_ovf_q = 1'b0;
        token_q   = 1'b0;
      end else if (blank && !quote_q) begin
        token_q = 1'b0;
      end else begin
        if (!token_q) begin
          r.token_start = 1'b1;
          count_token();
        end
        r.out_char   = ch;
        r.char_valid = 1'b1;
      end
      blank_q = blank;
      if (!closing) begin
        r.token_number   = latest_token(tok_cnt_q);
        r.segment_number = seg_cnt_q[SEG_NUM_W-1:0];
      end
      r.line_overflow = seg_ovf_q;
    end
  endtask

  task automatic check_field(input string name, input logic [7:0] want,
                             input logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      error_count++;
    end
  endtask

  // Byte channel: predict on every accepted transaction.
  always @(posedge clk) begin
    cll_result_t marks;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      tokenise_byte(in_ch.char_code, in_ch.is_end, marks);
      expected_marks.push_back(marks);
      byte_taken = 1'b1;
    end
  end

  // Byte channel driver; valid is only ever lowered between transactions.
  always @(negedge clk) begin
    line_item_t nxt;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || byte_taken) begin
      if (pending_items.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
        nxt = pending_items.pop_front();
        in_ch.valid     <= 1'b1;
        in_ch.char_code <= nxt.code;
        in_ch.is_end    <= nxt.eol;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
    byte_taken = 1'b0;
    out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // Result channel: compare each transaction with the oldest prediction.
  always @(posedge clk) begin
    cll_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_marks.size() == 0) begin
        $display("%0t: result with nothing expected, out_char %0h", $time,
                 out_ch.out_char);
        error_count++;
      end else begin
        want = expected_marks.pop_front();
        check_field("out_char", want.out_char, out_ch.out_char);
        check_field("char_valid", 8'(want.char_valid), 8'(out_ch.char_valid));
        check_field("token_start", 8'(want.token_start), 8'(out_ch.token_start));
        check_field("token_number", 8'(want.token_number), 8'(out_ch.token_number));
        check_field("segment_number", 8'(want.segment_number),
                    8'(out_ch.segment_number));
        check_field("segment_end", 8'(want.segment_end), 8'(out_ch.segment_end));
        check_field("segment_tokens", 8'(want.segment_tokens),
                    8'(out_ch.segment_tokens));
        check_field("segment_overflow", 8'(want.segment_overflow),
                    8'(out_ch.segment_overflow));
        check_field("line_end", 8'(want.line_end), 8'(out_ch.line_end));
        check_field("line_overflow", 8'(want.line_overflow), 8'(out_ch.line_overflow));
        check_field("char_dropped", 8'(want.char_dropped), 8'(out_ch.char_dropped));
      end
    end
  end

  task automatic push_byte(input logic [CHAR_W-1:0] c);
    pending_items.push_back('{code: c, eol: 1'b0});
    items_queued++;
  endtask

  // The byte carried by an end-of-line item is meant to be ignored.
  task automatic push_eol();
    pending_items.push_back('{code: CHAR_W'($urandom), eol: 1'b1});
    items_queued++;
  endtask

  task automatic push_blanks(input int n);
    repeat (n) push_byte($urandom_range(1) ? CH_SPACE : CH_TAB);
  endtask

  // Mostly characters with a meaning to the lexer; 8'h61 is a lower-case a.
  function automatic logic [CHAR_W-1:0] pick_special();
    case ($urandom_range(5))
      0: return CH_SPACE;
      1: return CH_TAB;
      2: return CH_SEMI;
      3: return CH_HASH;
      4: return CH_QUOTE;
      default: return 8'h61 + 8'($urandom_range(25));
    endcase
  endfunction

  // A word of letters, odd bytes, quoted pieces and the occasional inner hash.
  task automatic push_word();
    int parts;
    parts = $urandom_range(1, 4);
    repeat (parts) begin
      case ($urandom_range(19))
        0: push_byte(CHAR_W'($urandom));
        1: begin
          push_byte(CH_QUOTE);
          repeat ($urandom_range(0, 3)) push_byte(pick_special());
          if ($urandom_range(9) != 0) push_byte(CH_QUOTE);
        end
        2: push_byte(CH_HASH);
        default: push_byte(8'h61 + 8'($urandom_range(25)));
      endcase
    end
  endtask

  // A well-formed line: segments of words, perhaps a comment, usually an end.
  task automatic push_line();
    int segs;
    int words;
    segs = ($urandom_range(9) == 0) ? $urandom_range(15, 18) : $urandom_range(1, 3);
    if ($urandom_range(15) == 0) push_byte(CH_HASH);
    for (int s = 0; s < segs; s++) begin
      if (s != 0) push_byte(CH_SEMI);
      words = ($urandom_range(7) == 0) ? $urandom_range(10, 18) : $urandom_range(0, 4);
      for (int w = 0; w < words; w++) begin
        if (w != 0 || $urandom_range(1)) push_blanks($urandom_range(1, 2));
        push_word();
      end
      if ($urandom_range(3) == 0) push_blanks(1);
    end
    if ($urandom_range(4) == 0) begin
      push_blanks(1);
      push_byte(CH_HASH);
      repeat ($urandom_range(0, 5)) push_byte(pick_special());
    end
    if ($urandom_range(19) != 0) push_eol();
  endtask

  task automatic fill_random(input int count);
    int target;
    target = items_queued + count;
    while (items_queued < target) begin
      if ($urandom_range(6) == 0) begin
        // Noise: loose bytes, sometimes cut short without an end item.
        repeat ($urandom_range(1, 12)) begin
          push_byte($urandom_range(1) ? CHAR_W'($urandom) : pick_special());
        end
        if ($urandom_range(1)) push_eol();
      end else begin
        push_line();
      end
    end
  endtask

  // Returns once every queued byte has been sent and every result checked.
  task automatic wait_drained();
    while (pending_items.size() != 0 || in_ch.valid || expected_marks.size() != 0) begin
      @(negedge clk);
    end
    repeat (4) @(negedge clk);
  endtask

  task automatic write_limits(input logic [LIMIT_W-1:0] tok,
                              input logic [LIMIT_W-1:0] seg);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_TOKEN_LIMIT;
    cfg_data  <= tok;
    @(negedge clk);
    cfg_index <= REG_SEGMENT_LIMIT;
    cfg_data  <= seg;
    @(negedge clk);
    cfg_we <= 1'b0;
    tok_limit_q = tok;
    seg_limit_q = seg;
  endtask

  initial begin
    #(TIMEOUT_NS);
    $display("tb_top: done, errors");
    $finish;
  end

  initial begin
    logic [LIMIT_W-1:0] tok_set [8];
    logic [LIMIT_W-1:0] seg_set [8];
    tok_set = '{5'd16, 5'd0, 5'd31, 5'd1, 5'd3, 5'd16, 5'd5, 5'd0};
    seg_set = '{5'd16, 5'd31, 5'd0, 5'd1, 5'd2, 5'd1, 5'd16, 5'd0};
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = REG_TOKEN_LIMIT;
    cfg_data        = '0;
    in_ch.valid     = 1'b0;
    in_ch.char_code = '0;
    in_ch.is_end    = 1'b0;
    out_ch.ready    = 1'b0;
    byte_taken      = 1'b0;
    items_queued    = 0;
    error_count     = 0;
    tx_idle_pct     = 10;
    rx_idle_pct     = 68;
    tok_limit_q     = LIMIT_MAX;
    seg_limit_q     = LIMIT_MAX;
    clear_line();
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    // Directed lines at the reset limits: a comment opening the line, then
    // extreme bytes, quoted blank and semicolon, an empty quoted token,
    // a hash inside a word and a hash after a blank.
    push_byte(CH_HASH);
    push_byte(8'h78);
    push_eol();
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(CH_SPACE);
    push_byte(CH_QUOTE);
    push_byte(CH_SPACE);
    push_byte(CH_SEMI);
    push_byte(CH_QUOTE);
    push_byte(CH_TAB);
    push_byte(CH_QUOTE);
    push_byte(CH_QUOTE);
    push_byte(CH_SEMI);
    push_byte(8'h61);
    push_byte(CH_HASH);
    push_byte(CH_SPACE);
    push_byte(CH_HASH);
    push_byte(8'h7A);
    push_eol();
    wait_drained();

    // Smallest limits: both overflows, and a quote left open at the end.
    write_limits(5'd1, 5'd1);
    push_byte(8'h61);
    push_byte(CH_SPACE);
    push_byte(8'h62);
    push_byte(CH_SEMI);
    push_byte(CH_QUOTE);
    push_eol();

    // Random phases over a spread of limits and three idling patterns.
    for (int p = 0; p < 8; p++) begin
      wait_drained();
      tx_idle_pct = (p < 3) ? 10 : ((p < 6) ? 68 : 0);
      rx_idle_pct = (p < 3) ? 68 : ((p < 6) ? 10 : 0);
      if (p == 7) begin
        tok_set[p] = LIMIT_W'($urandom);
        seg_set[p] = LIMIT_W'($urandom);
      end
      write_limits(tok_set[p], seg_set[p]);
      if (p == 0) begin
        // One line longer than the lexer takes.
        for (int i = 0; i < LINE_LEN + 20; i++) begin
          push_byte((i % 6 == 5) ? CH_SPACE : 8'h61 + 8'(i % 26));
        end
        push_eol();
      end
      fill_random(40);
    end
    wait_drained();

    if (error_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
